// File: sv/ttlrl_pkg.sv
`timescale 1ns / 1ps
package ttlrl_pkg;

  localparam int LOCK_ENTRIES_DEF = 16;
  localparam int RATE_ENTRIES_DEF = 16;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 64;
  localparam int NOW_W  = 32;
  localparam int DUR_W  = 16;
  localparam int LIM_W  = 16;
  localparam int TIME_W = 33;
  localparam int CNT_W  = 16;

  typedef enum logic [1:0] {
    OP_TRY_LOCK = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_ALLOW    = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  // One classified request as it travels from the front end to the engine.
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key_id;
    logic [NOW_W-1:0] now_seconds;
    logic [DUR_W-1:0] duration_seconds;
    logic [LIM_W-1:0] request_limit;
    logic             purge;
    logic             use_lock;
    logic             use_rate;
  } req_t;

  typedef struct packed {
    logic granted;
    logic table_full;
  } rsp_t;

endpackage

// File: sv/ttlrl_front.sv
`timescale 1ns / 1ps
// Accepts request beats, decodes the operation and keeps a two-deep queue
// of classified requests for the table engine.
module ttlrl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ttlrl_pkg::req_t       in_req,
  output logic                  q_valid,
  input  logic                  q_ready,
  output ttlrl_pkg::req_t       q_req
);

  ttlrl_pkg::req_t q_mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  ttlrl_pkg::req_t cls;
  logic            push, pop;

  always_comb begin
    cls          = in_req;
    cls.purge    = (in_req.op == ttlrl_pkg::OP_TRY_LOCK) ||
                   (in_req.op == ttlrl_pkg::OP_ALLOW);
    cls.use_lock = (in_req.op == ttlrl_pkg::OP_TRY_LOCK) ||
                   (in_req.op == ttlrl_pkg::OP_RELEASE);
    cls.use_rate = (in_req.op == ttlrl_pkg::OP_ALLOW);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: sv/ttlrl_engine.sv
`timescale 1ns / 1ps
// Walks both tables one entry per cycle: a purge pass (try-lock, allow),
// then a search pass over the table used (not op 3) and an update state.
module ttlrl_engine #(
  parameter int LOCK_ENTRIES = ttlrl_pkg::LOCK_ENTRIES_DEF,
  parameter int RATE_ENTRIES = ttlrl_pkg::RATE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  ttlrl_pkg::req_t q_req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ttlrl_pkg::rsp_t rsp
);

  localparam int LW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int RW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
  localparam int MAXN = (LOCK_ENTRIES > RATE_ENTRIES) ? LOCK_ENTRIES : RATE_ENTRIES;
  localparam int IW = $clog2(MAXN + 1);
  localparam int TW = ttlrl_pkg::TIME_W;
  localparam int CW = ttlrl_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PURGE  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_UPDATE = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [LOCK_ENTRIES-1:0]       lock_valid_r;
  logic [ttlrl_pkg::KEY_W-1:0]   lock_key_r    [LOCK_ENTRIES];
  logic [TW-1:0]                 lock_expiry_r [LOCK_ENTRIES];
  logic [RATE_ENTRIES-1:0]       rate_valid_r;
  logic [ttlrl_pkg::KEY_W-1:0]   rate_key_r    [RATE_ENTRIES];
  logic [TW-1:0]                 rate_end_r    [RATE_ENTRIES];
  logic [CW-1:0]                 rate_count_r  [RATE_ENTRIES];

  ttlrl_pkg::req_t req_r;
  logic [IW-1:0]   idx_r;
  logic            hit_r, free_r;
  logic [LW-1:0]   lfree_r;
  logic [RW-1:0]   rhit_r, rfree_r;
  ttlrl_pkg::rsp_t rsp_r;

  logic [TW-1:0] now_ext, new_end;
  logic [LW-1:0] li;
  logic [RW-1:0] ri;

  assign now_ext  = {1'b0, req_r.now_seconds};
  assign new_end  = now_ext + {{(TW-ttlrl_pkg::DUR_W){1'b0}}, req_r.duration_seconds};
  assign li       = idx_r[LW-1:0];
  assign ri       = idx_r[RW-1:0];
  assign q_ready  = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp      = rsp_r;

  logic [IW-1:0] last_idx;
  always_comb begin
    if (req_r.use_rate) begin
      last_idx = IW'(RATE_ENTRIES - 1);
    end else begin
      last_idx = IW'(LOCK_ENTRIES - 1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_req.purge) begin
            state_nxt = S_PURGE;
          end else if (q_req.use_lock) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_PURGE: begin
        if (idx_r == IW'(MAXN - 1)) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (idx_r == last_idx) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: state_nxt = S_RESP;
      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lock_valid_r <= '0;
      rate_valid_r <= '0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: idx_r <= '0;
        S_PURGE: begin
          if (idx_r < IW'(LOCK_ENTRIES)) begin
            if (lock_valid_r[li] && lock_expiry_r[li] <= now_ext) begin
              lock_valid_r[li] <= 1'b0;
            end
          end
          if (idx_r < IW'(RATE_ENTRIES)) begin
            if (rate_valid_r[ri] && rate_end_r[ri] <= now_ext) begin
              rate_valid_r[ri] <= 1'b0;
            end
          end
          idx_r <= (idx_r == IW'(MAXN - 1)) ? '0 : idx_r + 1'b1;
        end
        S_SEARCH: begin
          // Release clears every matching entry as it walks.
          if (req_r.op == ttlrl_pkg::OP_RELEASE &&
              lock_valid_r[li] && lock_key_r[li] == req_r.key_id) begin
            lock_valid_r[li] <= 1'b0;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_UPDATE: begin
          if (req_r.op == ttlrl_pkg::OP_TRY_LOCK && !hit_r && free_r) begin
            lock_valid_r[lfree_r] <= 1'b1;
          end
          if (req_r.op == ttlrl_pkg::OP_ALLOW && !hit_r && free_r) begin
            rate_valid_r[rfree_r] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: search flags, table payload and the response register.
  logic [CW-1:0] cur_cnt;
  logic [TW-1:0] cur_end;
  logic          fresh;
  always_comb begin
    if (hit_r) begin
      cur_cnt = rate_count_r[rhit_r];
      cur_end = rate_end_r[rhit_r];
    end else begin
      cur_cnt = '0;
      cur_end = '0;
    end
    fresh = (cur_cnt == '0) || (cur_end <= now_ext);
    if (fresh) begin
      cur_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r  <= q_req;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        lfree_r <= '0; rhit_r <= '0; rfree_r <= '0;
        rsp_r  <= '0;
      end
      S_SEARCH: begin
        if (req_r.use_rate) begin
          if (rate_valid_r[ri] && rate_key_r[ri] == req_r.key_id && !hit_r) begin
            hit_r <= 1'b1; rhit_r <= ri;
          end
          if (!rate_valid_r[ri] && !free_r) begin
            free_r <= 1'b1; rfree_r <= ri;
          end
        end else begin
          if (lock_valid_r[li] && lock_key_r[li] == req_r.key_id) begin
            hit_r <= 1'b1;
          end
          if (!lock_valid_r[li] && !free_r) begin
            free_r <= 1'b1; lfree_r <= li;
          end
        end
      end
      S_UPDATE: begin
        if (req_r.op == ttlrl_pkg::OP_TRY_LOCK) begin
          if (!hit_r) begin
            if (free_r) begin
              lock_key_r[lfree_r]    <= req_r.key_id;
              lock_expiry_r[lfree_r] <= new_end;
              rsp_r.granted          <= 1'b1;
            end else begin
              rsp_r.table_full <= 1'b1;
            end
          end
        end else if (req_r.op == ttlrl_pkg::OP_ALLOW) begin
          if (!hit_r && !free_r) begin
            rsp_r.table_full <= 1'b1;
          end else begin
            if (!hit_r) begin
              rate_key_r[rfree_r] <= req_r.key_id;
            end
            if (fresh) begin
              rate_end_r[hit_r ? rhit_r : rfree_r] <= new_end;
            end
            if ({1'b0, cur_cnt} >= {1'b0, req_r.request_limit}) begin
              rate_count_r[hit_r ? rhit_r : rfree_r] <= cur_cnt;
            end else begin
              rate_count_r[hit_r ? rhit_r : rfree_r] <= cur_cnt + 1'b1;
              rsp_r.granted <= 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/ttlrl_out.sv
`timescale 1ns / 1ps
// Output register: holds one result beat so the engine can go back to idle.
module ttlrl_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rsp_valid,
  output logic            rsp_ready,
  input  ttlrl_pkg::rsp_t rsp,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata
);

  logic            valid_r, valid_nxt;
  ttlrl_pkg::rsp_t data_r;

  assign rsp_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, data_r.table_full, data_r.granted};

  always_comb begin
    valid_nxt = valid_r;
    if (rsp_ready) begin
      valid_nxt = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      data_r <= rsp;
    end
  end

endmodule

// File: sv/ttl_lock_and_rate_limit_table.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid/in_tready   | in_tuser: op; in_tdata: key_id, now_seconds,
//         |     |                       |   duration_seconds, request_limit
// out_    | out | out_tvalid/out_tready | out_tdata: granted, table_full
//
// A try-lock or allow passes through an idle state that takes the beat, a purge
// pass over both tables, a search pass over the table it uses, an update state
// and a response state. A release skips the purge; op 3 goes from idle straight
// to the response. The table engine walks one entry per cycle. Reset is
// synchronous, active low, and clears all valid bits at once. A two-beat queue
// lets input beats land while the engine works, and a stalled result beat waits
// in the output register.
module ttl_lock_and_rate_limit_table #(
  parameter int LOCK_ENTRIES = ttlrl_pkg::LOCK_ENTRIES_DEF,
  parameter int RATE_ENTRIES = ttlrl_pkg::RATE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // From bit 0: op[1:0].
  input  logic [1:0]    in_tuser,
  // From bit 0: key_id[63:0], now_seconds[95:64], duration_seconds[111:96],
  // request_limit[127:112].
  input  logic [127:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // From bit 0: granted[0], table_full[1], zeros to 7.
  output logic [7:0]    out_tdata
);

  ttlrl_pkg::req_t in_req, q_req;
  ttlrl_pkg::rsp_t rsp;
  logic            q_valid, q_ready, rsp_valid, rsp_ready;

  // Classification fields are filled in by the front end.
  always_comb begin
    in_req                  = '0;
    in_req.op               = ttlrl_pkg::op_t'(in_tuser);
    in_req.key_id           = in_tdata[63:0];
    in_req.now_seconds      = in_tdata[95:64];
    in_req.duration_seconds = in_tdata[111:96];
    in_req.request_limit    = in_tdata[127:112];
  end

  ttlrl_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  ttlrl_engine #(
    .LOCK_ENTRIES(LOCK_ENTRIES), .RATE_ENTRIES(RATE_ENTRIES)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  ttlrl_out u_out (
    .clk(clk), .rst_n(rst_n),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

// File: sv/ttlrl_checker.sv
`timescale 1ns / 1ps
module ttlrl_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic [127:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [7:0]   out_tdata
);

  // A result never grants and reports a full table at once.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("granted and table_full both set");

  // Padding bits of the result stay zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'd0))
    else $error("result padding not zero");

  // A held result beat keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A request beat that waits for the block keeps its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("stalled request changed");

  // A result can only follow an accepted request, so none appears right after reset.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ttl_lock_and_rate_limit_table ttlrl_checker u_ttlrl_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
  .in_tdata(in_tdata),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
